FILE: rtl/acosu_pkg.sv
// Shared widths, coefficients, bundle types and rounding helper for the arccos unit.
package acosu_pkg;

    // Internal working point: Q30
    localparam int WB    = 30;
    localparam int X_W   = 16;          // argument field
    localparam int ANG_W = 17;          // angle field

    localparam int Z_W   = 30;          // z <= 2^29
    localparam int Q_W   = WB + 1;      // q in (2^29, 2^30]
    localparam int N_W   = 2 * WB;      // products before rescale, dividend
    localparam int M1_W  = 54;          // |P2| * z
    localparam int NI_W  = 26;          // |P1 + z*P2|
    localparam int M2_W  = 56;          // |inner| * z
    localparam int P_W   = 28;          // p
    localparam int ZP_W  = 58;          // z * p
    localparam int QB    = WB;          // quotient bits produced by the divider
    localparam int S_W   = 30;          // square root
    localparam int SR_W  = 32;          // square root remainder
    localparam int RES_W = 32;          // 2*(s + t)

    // Coefficient magnitudes in Q30; P1, P2 and Q1 are negative
    localparam logic [P_W-1:0]  C_P0     = 28'd178956112;
    localparam logic [NI_W-1:0] C_P1_MAG = 26'd45895400;
    localparam logic [23:0]     C_P2_MAG = 24'd9294699;
    localparam logic [29:0]     C_Q1_MAG = 30'd758737792;

    localparam logic [Q_W-1:0]   ONE_Q     = Q_W'(1) << WB;
    localparam logic [N_W:0]     HALF_Q    = (N_W + 1)'(1) << (WB - 1);
    localparam logic [ANG_W-1:0] ANGLE_MAX = '1;

    // Front end to divider / root
    typedef struct packed {
        logic           valid;
        logic [N_W-1:0] n;      // z*p + q/2
        logic [Q_W-1:0] q;
        logic [Z_W-1:0] z;
    } t_front;

    typedef struct packed {
        logic          valid;
        logic [QB-1:0] quot;
    } t_div_out;

    typedef struct packed {
        logic [S_W-1:0]  root;  // floor
        logic [SR_W-1:0] rem;
    } t_sqrt_out;

    // Rescale a Q60 magnitude to Q30, half rounds up
    function automatic logic [WB:0] rnd_q30(input logic [N_W-1:0] a);
        logic [N_W:0] w_sum;
        w_sum = {1'b0, a} + HALF_Q;
        return w_sum[N_W:WB];
    endfunction

endpackage

FILE: rtl/arccos_upper_range_approx_top.sv
// Top level of the arccos unit: front end, divider and root in parallel, result combine.
//
//  channel   direction  handshake                       payload
//  --------  ---------  ------------------------------  ---------------------------
//  x         in         i_x_valid / o_x_ready           i_x_value [15:0], Q.FRAC_BITS
//  angle     out        o_angle_valid / i_angle_ready   o_angle   [16:0], Q.FRAC_BITS
//
// One beat enters per cycle while the output is not stalled: 7 front-end stages, 30 divider
// stages run side by side with 30 root stages, then 4 combine stages incl. output register.
// The 30-stage divider and root set the depth; each stage resolves one result bit.
// i_rst_n (synchronous, active low) clears the valid bits only; data is not reset.
// All stages advance together whenever the output register is empty or being taken,
// so a stall freezes the whole pipe and no beat is lost or repeated.
module arccos_upper_range_approx_top import acosu_pkg::*; #(
    parameter int FRAC_BITS = 16    // 12 .. 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_x_valid,
    output logic             o_x_ready,
    input  logic [X_W-1:0]   i_x_value,
    output logic             o_angle_valid,
    input  logic             i_angle_ready,
    output logic [ANG_W-1:0] o_angle
);

    localparam int SH = WB - FRAC_BITS;   // Q30 -> output scaling

    logic      w_adv;
    t_front    w_front;
    t_div_out  w_div;
    t_sqrt_out w_sqrt;

    // combine stages
    logic             r_f1_vld, r_f2_vld, r_f3_vld, r_angle_valid;
    logic [S_W-1:0]   n_f1_s, r_f1_s, r_f2_s;
    logic [QB-1:0]    r_f1_r;
    logic [N_W-1:0]   n_f2_prod, r_f2_prod;
    logic [RES_W-1:0] n_f3_res, r_f3_res;
    logic [RES_W-1:0] w_sum;
    logic [RES_W:0]   w_ang_full;
    logic [ANG_W-1:0] n_angle, r_angle;

    // whole pipe moves when the output slot is free or being drained
    assign w_adv     = !r_angle_valid || i_angle_ready;
    assign o_x_ready = w_adv;

    acosu_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_x_valid),
        .i_x     (i_x_value),
        .o_front (w_front)
    );

    // r = (z*p + q/2) / q
    acosu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_front (w_front),
        .o_div   (w_div)
    );

    // floor sqrt(z * 2^30) and its remainder, aligned with the divider
    acosu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_front (w_front),
        .o_sqrt  (w_sqrt)
    );

    // round the root to nearest: remainder above the floor root means round up
    assign n_f1_s = w_sqrt.root + S_W'(w_sqrt.rem > SR_W'(w_sqrt.root));

    // t = s*r, still Q60
    assign n_f2_prod = N_W'(r_f1_s) * N_W'(r_f1_r);

    // res = 2*(s + t); s + t stays below 2^31
    assign w_sum    = RES_W'(r_f2_s) + RES_W'(rnd_q30(r_f2_prod));
    assign n_f3_res = {w_sum[RES_W-2:0], 1'b0};

    // scale to the output point, half rounds up
    if (SH > 0) begin : g_round
        localparam logic [RES_W:0] RND_HALF = (RES_W + 1)'(1) << (SH - 1);
        logic [RES_W:0] w_rnd;
        assign w_rnd      = {1'b0, r_f3_res} + RND_HALF;
        assign w_ang_full = w_rnd >> SH;
    end else begin : g_noround
        assign w_ang_full = {1'b0, r_f3_res};
    end

    // saturate to the field
    assign n_angle = (w_ang_full > (RES_W + 1)'(ANGLE_MAX)) ? ANGLE_MAX
                                                          : w_ang_full[ANG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld      <= 1'b0;
            r_f2_vld      <= 1'b0;
            r_f3_vld      <= 1'b0;
            r_angle_valid <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld      <= w_div.valid;
            r_f2_vld      <= r_f1_vld;
            r_f3_vld      <= r_f2_vld;
            r_angle_valid <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_s    <= n_f1_s;
            r_f1_r    <= w_div.quot;
            r_f2_s    <= r_f1_s;
            r_f2_prod <= n_f2_prod;
            r_f3_res  <= n_f3_res;
            r_angle   <= n_angle;
        end
    end

    assign o_angle_valid = r_angle_valid;
    assign o_angle       = r_angle;

endmodule

FILE: rtl/acosu_front.sv
// Front end: z = (1 - x)/2, Horner numerator and denominator, dividend z*p + q/2.
module acosu_front import acosu_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [X_W-1:0] i_x,
    output t_front         o_front
);

    localparam int SH  = WB - FRAC_BITS;
    localparam int XW  = (X_W + SH > Q_W) ? X_W + SH : Q_W;
    localparam int NST = 7;

    logic [NST-1:0] r_vld;

    // stage A: z
    logic [XW-1:0]  w_x30, w_x30c, w_diff;
    logic [Z_W-1:0] n_a_z, r_a_z;
    // stage B: products with P2 and Q1
    logic [M1_W-1:0] n_b_m1, r_b_m1;
    logic [N_W-1:0]  n_b_mq, r_b_mq;
    logic [Z_W-1:0]  r_b_z;
    // stage C: inner, q
    logic [NI_W-1:0] n_c_ni, r_c_ni;
    logic [Q_W-1:0]  n_c_q, r_c_q;
    logic [Z_W-1:0]  r_c_z;
    // stage D: inner * z
    logic [M2_W-1:0] n_d_m2, r_d_m2;
    logic [Q_W-1:0]  r_d_q;
    logic [Z_W-1:0]  r_d_z;
    // stage E: p
    logic [P_W:0]    w_e_pd;
    logic [P_W-1:0]  n_e_p, r_e_p;
    logic [Q_W-1:0]  r_e_q;
    logic [Z_W-1:0]  r_e_z;
    // stage F: z * p
    logic [ZP_W-1:0] n_f_zp, r_f_zp;
    logic [Q_W-1:0]  r_f_q;
    logic [Z_W-1:0]  r_f_z;
    // stage G: dividend
    logic [N_W-1:0]  n_g_n, r_g_n;
    logic [Q_W-1:0]  r_g_q;
    logic [Z_W-1:0]  r_g_z;

    // x >= 1 only possible with few fraction bits; clamp to 1
    assign w_x30  = XW'(i_x) << SH;
    assign w_x30c = (w_x30 > XW'(ONE_Q)) ? XW'(ONE_Q) : w_x30;
    assign w_diff = XW'(ONE_Q) - w_x30c;
    assign n_a_z  = w_diff[Z_W:1];

    assign n_b_m1 = M1_W'(C_P2_MAG) * M1_W'(r_a_z);
    assign n_b_mq = N_W'(C_Q1_MAG) * N_W'(r_a_z);

    assign n_c_ni = C_P1_MAG + NI_W'(rnd_q30(N_W'(r_b_m1)));
    assign n_c_q  = ONE_Q - rnd_q30(r_b_mq);

    assign n_d_m2 = M2_W'(r_c_ni) * M2_W'(r_c_z);

    assign w_e_pd = {1'b0, C_P0} - (P_W + 1)'(rnd_q30(N_W'(r_d_m2)));
    assign n_e_p  = w_e_pd[P_W] ? '0 : w_e_pd[P_W-1:0];

    assign n_f_zp = ZP_W'(r_e_z) * ZP_W'(r_e_p);

    assign n_g_n  = N_W'(r_f_zp) + N_W'(r_f_q[Q_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_z  <= n_a_z;

            r_b_m1 <= n_b_m1;
            r_b_mq <= n_b_mq;
            r_b_z  <= r_a_z;

            r_c_ni <= n_c_ni;
            r_c_q  <= n_c_q;
            r_c_z  <= r_b_z;

            r_d_m2 <= n_d_m2;
            r_d_q  <= r_c_q;
            r_d_z  <= r_c_z;

            r_e_p  <= n_e_p;
            r_e_q  <= r_d_q;
            r_e_z  <= r_d_z;

            r_f_zp <= n_f_zp;
            r_f_q  <= r_e_q;
            r_f_z  <= r_e_z;

            r_g_n  <= n_g_n;
            r_g_q  <= r_f_q;
            r_g_z  <= r_f_z;
        end
    end

    assign o_front.valid = r_vld[NST-1];
    assign o_front.n     = r_g_n;
    assign o_front.q     = r_g_q;
    assign o_front.z     = r_g_z;

endmodule

FILE: rtl/acosu_div.sv
// Pipelined restoring divider: one quotient bit per stage, r = n / q.
module acosu_div import acosu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_front   i_front,
    output t_div_out o_div
);

    localparam int RW = Q_W;    // partial remainder stays below q

    logic          r_vld [QB];
    logic [QB-1:0] r_quo [QB];
    logic [RW-1:0] r_rem [QB-1];
    logic [Q_W-1:0] r_den [QB-1];
    logic [QB-1:0] r_num [QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic           w_vld;
        logic [RW-1:0]  w_rem;
        logic [Q_W-1:0] w_den;
        logic [QB-1:0]  w_num;
        logic [QB-1:0]  w_quo;
        logic [RW:0]    w_sh, w_dif;
        logic           w_ge;

        if (k == 0) begin : g_first
            // n < q * 2^QB, so the upper half is already below q
            assign w_vld = i_front.valid;
            assign w_rem = RW'(i_front.n[N_W-1:QB]);
            assign w_den = i_front.q;
            assign w_num = i_front.n[QB-1:0];
            assign w_quo = '0;
        end else begin : g_next
            assign w_vld = r_vld[k-1];
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_num = r_num[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_sh  = {w_rem, w_num[QB-1-k]};
        assign w_ge  = (w_sh >= {1'b0, w_den});
        assign w_dif = w_sh - {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_quo[k] <= {w_quo[QB-2:0], w_ge};
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= w_ge ? w_dif[RW-1:0] : w_sh[RW-1:0];
                    r_den[k] <= w_den;
                    r_num[k] <= w_num;
                end
            end
        end
    end

    assign o_div.valid = r_vld[QB-1];
    assign o_div.quot  = r_quo[QB-1];

endmodule

FILE: rtl/acosu_sqrt.sv
// Pipelined digit-by-digit square root of z * 2^30, one root bit per stage.
module acosu_sqrt import acosu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_adv,
    input  t_front    i_front,
    output t_sqrt_out o_sqrt
);

    localparam int SB  = S_W;       // root bits, one per stage
    localparam int ZST = Z_W / 2;   // stages that still consume bits of z

    logic [S_W-1:0]  r_y [SB];
    logic [SR_W-1:0] r_r [SB];
    logic [Z_W-1:0]  r_z [ZST-1];

    for (genvar k = 0; k < SB; k++) begin : g_stage
        logic [S_W-1:0]  w_y;
        logic [SR_W-1:0] w_r;
        logic [1:0]      w_pair;
        logic [SR_W+1:0] w_rp, w_t, w_dif;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign w_y = '0;
            assign w_r = '0;
        end else begin : g_next
            assign w_y = r_y[k-1];
            assign w_r = r_r[k-1];
        end

        // radicand is z followed by WB zero bits
        if (k == 0) begin : g_pair_in
            assign w_pair = i_front.z[Z_W-1 -: 2];
        end else if (k < ZST) begin : g_pair_z
            assign w_pair = r_z[k-1][Z_W-1-2*k -: 2];
        end else begin : g_pair_zero
            assign w_pair = 2'b00;
        end

        if (k == 0 && ZST > 1) begin : g_zload
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_z[k] <= i_front.z;
                end
            end
        end else if (k < ZST - 1) begin : g_zcarry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_z[k] <= r_z[k-1];
                end
            end
        end

        assign w_rp  = {w_r, w_pair};
        assign w_t   = (SR_W + 2)'({w_y, 2'b01});
        assign w_ge  = (w_rp >= w_t);
        assign w_dif = w_rp - w_t;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_y[k] <= {w_y[S_W-2:0], w_ge};
                r_r[k] <= w_ge ? w_dif[SR_W-1:0] : w_rp[SR_W-1:0];
            end
        end
    end

    assign o_sqrt.root = r_y[SB-1];
    assign o_sqrt.rem  = r_r[SB-1];

endmodule
